// ===== rtl/core/fsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared widths, register indexes and types of the fault severity aggregator.
// ----------------------------------------------------------------------------
package fsa_pkg;

	// table geometry
	localparam int TABLE_SLOTS     = 8;
	localparam int DEF_MAX_SOURCES = 8;

	// field widths
	localparam int ID_W       = 16;
	localparam int CODE_W     = 16;
	localparam int SEV_W      = 8;
	localparam int CNT_W      = 4;
	localparam int RPT_W      = 32;
	localparam int SEQ_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_IDS_0_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_IDS_2_3 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_IDS_4_5 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_IDS_6_7 = 3'd4;

	// per-source state held in the entry memory
	typedef struct packed {
		logic [CODE_W-1:0] live_code;
		logic [CODE_W-1:0] held_code;
		logic [SEV_W-1:0]  current_sev;
		logic [SEV_W-1:0]  peak_sev;
		logic [RPT_W-1:0]  rpt_total;
	} entry_t;

	// system snapshot
	typedef struct packed {
		logic              valid;
		logic [SEV_W-1:0]  worst_sev;
		logic [CNT_W-1:0]  active_n;
		logic [CNT_W-1:0]  latched_n;
		logic [ID_W-1:0]   worst_id;
		logic [CODE_W-1:0] worst_code;
	} snap_t;

	// accumulator control from the sequencer
	typedef struct packed {
		logic clear;
		logic en;
	} acc_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/fsa_entry_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsa_entry_mem
// Per-source state memory, one write and one registered read port; entries
// not yet written read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module fsa_entry_mem #(
	parameter int DEPTH = fsa_pkg::DEF_MAX_SOURCES,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_en,
	input  wire [AW-1:0]        wr_addr,
	input  fsa_pkg::entry_t     wr_data,
	input  wire                 rd_en,
	input  wire [AW-1:0]        rd_addr,
	output fsa_pkg::entry_t     rd_data
);
	import fsa_pkg::*;

	entry_t           mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	entry_t           rd_word_q;
	logic             rd_vld_q;

	// storage array and registered read word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem_q[rd_addr];
		end
	end

	// valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// unwritten entry reads as zero
	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule
`default_nettype wire

// ===== rtl/core/fsa_snap_acc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsa_snap_acc
// Snapshot accumulator: folds one entry per beat into the active and latched
// counts and the first strictly highest active severity.
// ----------------------------------------------------------------------------
module fsa_snap_acc (
	input  wire                        clk,
	input  wire                        arst_n,
	input  fsa_pkg::acc_ctl_t          ctl,
	input  wire [fsa_pkg::ID_W-1:0]    beat_id,
	input  fsa_pkg::entry_t            beat_entry,
	output fsa_pkg::snap_t             snap
);
	import fsa_pkg::*;

	logic [SEV_W-1:0]  worst_sev_q;
	logic [CNT_W-1:0]  active_n_q;
	logic [CNT_W-1:0]  latched_n_q;
	logic [ID_W-1:0]   worst_id_q;
	logic [CODE_W-1:0] worst_code_q;

	// accumulate one entry per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			worst_sev_q  <= '0;
			active_n_q   <= '0;
			latched_n_q  <= '0;
			worst_id_q   <= '0;
			worst_code_q <= '0;
		end else if (ctl.clear) begin
			worst_sev_q  <= '0;
			active_n_q   <= '0;
			latched_n_q  <= '0;
			worst_id_q   <= '0;
			worst_code_q <= '0;
		end else if (ctl.en) begin
			if (beat_entry.held_code != '0) begin
				latched_n_q <= latched_n_q + 1'b1;
			end
			if (beat_entry.live_code != '0) begin
				active_n_q <= active_n_q + 1'b1;
				// strict compare keeps the earlier entry on a tie
				if (beat_entry.current_sev > worst_sev_q) begin
					worst_sev_q  <= beat_entry.current_sev;
					worst_id_q   <= beat_id;
					worst_code_q <= beat_entry.live_code;
				end
			end
		end
	end

	assign snap = '{
		valid:      1'b1,
		worst_sev:  worst_sev_q,
		active_n:   active_n_q,
		latched_n:  latched_n_q,
		worst_id:   worst_id_q,
		worst_code: worst_code_q
	};

endmodule
`default_nettype wire

// ===== rtl/core/fault_severity_aggregator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fault_severity_aggregator
// Fault report table with per-source state in memory and a published system
// snapshot recomputed after every known report.
// ----------------------------------------------------------------------------
// A report from a known source passes through the id lookup, the
// read-modify-write of the source's entry, a walk that reads every table
// entry in use (at most MAX_SOURCES) through the single read port of the
// entry memory, and a final step that compares and publishes the snapshot
// before the next report transfers. A report with an unknown id goes from
// the lookup straight to the final step. A new report transfers while the
// previous result still waits in the output register; it only finishes
// once that register is free. Configuration writes are always taken
// (cfg_ready stays high) and must come while no report is in flight. Entry
// state starts at zero after reset through valid bits, so no clearing pass
// is needed.
module fault_severity_aggregator #(
	parameter int MAX_SOURCES = fsa_pkg::DEF_MAX_SOURCES
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// report channel
	input  wire                              report_valid,
	output logic                             report_stall,
	input  wire [fsa_pkg::ID_W-1:0]          src_id,
	input  wire [fsa_pkg::CODE_W-1:0]        fault_code,
	input  wire [fsa_pkg::SEV_W-1:0]         severity,
	// result channel
	output logic                             result_valid,
	input  wire                              result_stall,
	output logic                             error,
	output logic                             published,
	output logic                             snapshot_valid,
	output logic [fsa_pkg::SEV_W-1:0]        system_worst_severity,
	output logic [fsa_pkg::CNT_W-1:0]        active_sources,
	output logic [fsa_pkg::CNT_W-1:0]        latched_sources,
	output logic [fsa_pkg::ID_W-1:0]         worst_source_id,
	output logic [fsa_pkg::CODE_W-1:0]       worst_code,
	output logic [fsa_pkg::SEQ_W-1:0]        sequence_res,
	output logic [fsa_pkg::RPT_W-1:0]        source_reports,
	output logic [fsa_pkg::SEV_W-1:0]        source_worst_severity,
	// configuration channel
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [fsa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [fsa_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import fsa_pkg::*;

	localparam int IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_MODIFY,
		S_WALK,
		S_FINISH
	} state_t;

	// configuration registers
	logic [CNT_W-1:0] source_count_q;
	logic [ID_W-1:0]  ids_q [TABLE_SLOTS];

	// sequencer state
	state_t            state_q;
	logic [ID_W-1:0]   sid_q;
	logic [CODE_W-1:0] code_q;
	logic [SEV_W-1:0]  sev_q;
	logic [IDX_W-1:0]  hit_q;
	logic              err_q;
	logic [RPT_W-1:0]  rpt_q;
	logic [SEV_W-1:0]  peak_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              beat_s1;
	logic [ID_W-1:0]   beat_id_s1;
	snap_t             pub_q;
	logic [SEQ_W-1:0]  seq_q;

	// result register
	logic              res_valid_q;
	logic              res_error_q;
	logic              res_pub_q;
	snap_t             res_snap_q;
	logic [SEQ_W-1:0]  res_seq_q;
	logic [RPT_W-1:0]  res_rpt_q;
	logic [SEV_W-1:0]  res_peak_q;

	// datapath
	logic [CNT_W-1:0]  n_use;
	logic              match_found;
	logic [IDX_W-1:0]  match_idx;
	logic              report_xfer;
	logic              walk_issue;
	logic              res_free;
	logic              res_load;
	logic              pub_now;
	logic              mem_rd_en;
	logic [IDX_W-1:0]  mem_rd_addr;
	logic              mem_wr_en;
	entry_t            mem_rd_data;
	entry_t            new_entry;
	acc_ctl_t          acc_ctl;
	snap_t             acc_snap;

	// entries in use, saturated to the table depth
	assign n_use = (source_count_q > CNT_W'(MAX_SOURCES)) ? CNT_W'(MAX_SOURCES)
	                                                      : source_count_q;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_count_q <= CNT_W'(1);
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				ids_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SOURCE_COUNT: begin
					source_count_q <= cfg_data[CNT_W-1:0];
				end
				REG_SOURCE_IDS_0_1: begin
					ids_q[0] <= cfg_data[ID_W-1:0];
					ids_q[1] <= cfg_data[2*ID_W-1:ID_W];
				end
				REG_SOURCE_IDS_2_3: begin
					ids_q[2] <= cfg_data[ID_W-1:0];
					ids_q[3] <= cfg_data[2*ID_W-1:ID_W];
				end
				REG_SOURCE_IDS_4_5: begin
					ids_q[4] <= cfg_data[ID_W-1:0];
					ids_q[5] <= cfg_data[2*ID_W-1:ID_W];
				end
				REG_SOURCE_IDS_6_7: begin
					ids_q[6] <= cfg_data[ID_W-1:0];
					ids_q[7] <= cfg_data[2*ID_W-1:ID_W];
				end
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

	// id lookup, first matching entry in use wins
	always_comb begin
		match_found = 1'b0;
		match_idx   = '0;
		for (int i = 0; i < MAX_SOURCES; i++) begin
			if (!match_found && (CNT_W'(i) < n_use) && (ids_q[i] == sid_q)) begin
				match_found = 1'b1;
				match_idx   = IDX_W'(i);
			end
		end
	end

	// entry update of the reporting source
	always_comb begin
		new_entry           = mem_rd_data;
		new_entry.rpt_total = mem_rd_data.rpt_total + 1'b1;
		if (code_q == '0) begin
			new_entry.live_code   = '0;
			new_entry.current_sev = '0;
		end else begin
			new_entry.live_code   = code_q;
			new_entry.current_sev = sev_q;
			new_entry.held_code   = code_q;
			if (sev_q > mem_rd_data.peak_sev) begin
				new_entry.peak_sev = sev_q;
			end
		end
	end

	// memory port control
	assign report_stall = (state_q != S_IDLE);
	assign report_xfer  = report_valid && !report_stall;
	assign walk_issue   = (state_q == S_WALK) && (cnt_q < n_use);
	assign mem_rd_en    = ((state_q == S_LOOKUP) && match_found) || walk_issue;
	assign mem_rd_addr  = (state_q == S_LOOKUP) ? match_idx : cnt_q[IDX_W-1:0];
	assign mem_wr_en    = (state_q == S_MODIFY);

	assign acc_ctl = '{clear: (state_q == S_MODIFY), en: beat_s1};

	// publish decision and output register availability
	assign pub_now  = !err_q && (acc_snap != pub_q);
	assign res_free = !res_valid_q || !result_stall;
	assign res_load = (state_q == S_FINISH) && res_free;

	fsa_entry_mem #(
		.DEPTH (MAX_SOURCES),
		.AW    (IDX_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_wr_en),
		.wr_addr (hit_q),
		.wr_data (new_entry),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	fsa_snap_acc u_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (acc_ctl),
		.beat_id    (beat_id_s1),
		.beat_entry (mem_rd_data),
		.snap       (acc_snap)
	);

	// sequencer, published snapshot and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sid_q       <= '0;
			code_q      <= '0;
			sev_q       <= '0;
			hit_q       <= '0;
			err_q       <= 1'b0;
			rpt_q       <= '0;
			peak_q      <= '0;
			cnt_q       <= '0;
			beat_s1     <= 1'b0;
			beat_id_s1  <= '0;
			pub_q       <= '0;
			seq_q       <= '0;
			res_valid_q <= 1'b0;
			res_error_q <= 1'b0;
			res_pub_q   <= 1'b0;
			res_snap_q  <= '0;
			res_seq_q   <= '0;
			res_rpt_q   <= '0;
			res_peak_q  <= '0;
		end else begin
			// output register fills on a finished report, empties on a result transfer
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end

			beat_s1    <= walk_issue;
			beat_id_s1 <= ids_q[cnt_q[IDX_W-1:0]];

			unique case (state_q)
				S_IDLE: begin
					if (report_xfer) begin
						sid_q   <= src_id;
						code_q  <= fault_code;
						sev_q   <= severity;
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					hit_q <= match_idx;
					err_q <= !match_found;
					if (match_found) begin
						state_q <= S_MODIFY;
					end else begin
						rpt_q   <= '0;
						peak_q  <= '0;
						state_q <= S_FINISH;
					end
				end
				S_MODIFY: begin
					rpt_q   <= new_entry.rpt_total;
					peak_q  <= new_entry.peak_sev;
					cnt_q   <= '0;
					state_q <= S_WALK;
				end
				S_WALK: begin
					// last beat folds into the accumulator on this edge
					if (cnt_q == n_use) begin
						state_q <= S_FINISH;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FINISH: begin
					if (res_free) begin
						res_error_q <= err_q;
						res_pub_q   <= pub_now;
						res_rpt_q   <= rpt_q;
						res_peak_q  <= peak_q;
						if (pub_now) begin
							pub_q      <= acc_snap;
							seq_q      <= seq_q + 1'b1;
							res_snap_q <= acc_snap;
							res_seq_q  <= seq_q + 1'b1;
						end else begin
							res_snap_q <= pub_q;
							res_seq_q  <= seq_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result ports
	assign result_valid          = res_valid_q;
	assign error                 = res_error_q;
	assign published             = res_pub_q;
	assign snapshot_valid        = res_snap_q.valid;
	assign system_worst_severity = res_snap_q.worst_sev;
	assign active_sources        = res_snap_q.active_n;
	assign latched_sources       = res_snap_q.latched_n;
	assign worst_source_id       = res_snap_q.worst_id;
	assign worst_code            = res_snap_q.worst_code;
	assign sequence_res          = res_seq_q;
	assign source_reports        = res_rpt_q;
	assign source_worst_severity = res_peak_q;

	// an unknown id never publishes
	a_err_no_pub: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(error && published))
		else $error("unknown source result flagged as published");

	// a publish bumps the sequence by exactly one
	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && res_free && pub_now) |=> (seq_q == $past(seq_q) + 1'b1))
		else $error("publish sequence did not advance by one");

	// the walk never runs past the entries in use
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (cnt_q <= n_use))
		else $error("snapshot walk ran past the entries in use");

	// a known report always leaves a valid snapshot behind
	a_snap_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !error) |-> snapshot_valid)
		else $error("known report without a valid snapshot");

endmodule
`default_nettype wire

// ===== tb/sv/tb_fault_severity_aggregator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fault_severity_aggregator
// Self-checking bench for the fault severity aggregator. Fault reports are
// queued by a stimulus sequence, sent by a clocked driver with random gaps,
// and predicted on transfer by a behavioral model of the source table and
// the published snapshot. A clocked monitor compares every result, field by
// field, in order. The source table is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_fault_severity_aggregator;
	import fsa_pkg::*;

	localparam int MAX_SOURCES    = DEF_MAX_SOURCES;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_REPORTS  = 305;
	localparam int SETTLE_CYCLES  = 20;

	typedef struct packed {
		logic [ID_W-1:0]   sid;
		logic [CODE_W-1:0] code;
		logic [SEV_W-1:0]  sev;
	} fault_report_t;

	typedef struct packed {
		logic             error;
		logic             published;
		snap_t            snap;
		logic [SEQ_W-1:0] seq;
		logic [RPT_W-1:0] reports;
		logic [SEV_W-1:0] src_peak;
	} fault_result_t;

	// clock, reset and block inputs
	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  report_valid = 1'b0;
	logic [ID_W-1:0]       src_id       = '0;
	logic [CODE_W-1:0]     fault_code   = '0;
	logic [SEV_W-1:0]      severity     = '0;
	logic                  result_stall = 1'b0;
	logic                  cfg_valid    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	// block outputs
	logic              report_stall;
	logic              result_valid;
	logic              error;
	logic              published;
	logic              snapshot_valid;
	logic [SEV_W-1:0]  system_worst_severity;
	logic [CNT_W-1:0]  active_sources;
	logic [CNT_W-1:0]  latched_sources;
	logic [ID_W-1:0]   worst_source_id;
	logic [CODE_W-1:0] worst_code;
	logic [SEQ_W-1:0]  sequence_res;
	logic [RPT_W-1:0]  source_reports;
	logic [SEV_W-1:0]  source_worst_severity;
	logic              cfg_ready;

	// predicted table configuration
	logic [3:0]        src_count;
	logic [ID_W-1:0]   tbl_id [TABLE_SLOTS];

	// predicted per-entry state and published snapshot
	logic [CODE_W-1:0] act_code   [TABLE_SLOTS];
	logic [CODE_W-1:0] latch_code [TABLE_SLOTS];
	logic [SEV_W-1:0]  cur_sev    [TABLE_SLOTS];
	logic [SEV_W-1:0]  peak_sev   [TABLE_SLOTS];
	logic [RPT_W-1:0]  rpt_cnt    [TABLE_SLOTS];
	logic [SEQ_W-1:0]  pub_seq;
	snap_t             pub_snap;

	fault_report_t report_queue[$];
	fault_result_t predicted_results[$];
	fault_report_t next_report;
	fault_result_t want_res;
	fault_result_t seen_res;

	logic rep_taken  = 1'b0;
	logic res_taken  = 1'b0;
	logic quiet      = 1'b0;
	int   send_gap   = 0;
	int   stall_left = 0;
	int   idle_cycles = 0;
	int   n_posted   = 0;
	int   n_accepted = 0;
	int   n_results  = 0;
	int   n_publish  = 0;
	int   n_unknown  = 0;
	int   n_cfg      = 0;
	int   failures   = 0;

	fault_severity_aggregator #(
		.MAX_SOURCES(MAX_SOURCES)
	) i_dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.report_valid         (report_valid),
		.report_stall         (report_stall),
		.src_id               (src_id),
		.fault_code           (fault_code),
		.severity             (severity),
		.result_valid         (result_valid),
		.result_stall         (result_stall),
		.error                (error),
		.published            (published),
		.snapshot_valid       (snapshot_valid),
		.system_worst_severity(system_worst_severity),
		.active_sources       (active_sources),
		.latched_sources      (latched_sources),
		.worst_source_id      (worst_source_id),
		.worst_code           (worst_code),
		.sequence_res         (sequence_res),
		.source_reports       (source_reports),
		.source_worst_severity(source_worst_severity),
		.cfg_valid            (cfg_valid),
		.cfg_ready            (cfg_ready),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data)
	);

	// 10 ns clock
	always #5 clk = ~clk;

	// number of table entries that take part in matching and the snapshot
	function automatic int entries_used();
		return (int'(src_count) > MAX_SOURCES) ? MAX_SOURCES : int'(src_count);
	endfunction

	// register write as seen by the table
	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		unique case (idx)
			REG_SOURCE_COUNT: src_count = val[3:0];
			REG_SOURCE_IDS_0_1: begin
				tbl_id[0] = val[15:0];
				tbl_id[1] = val[31:16];
			end
			REG_SOURCE_IDS_2_3: begin
				tbl_id[2] = val[15:0];
				tbl_id[3] = val[31:16];
			end
			REG_SOURCE_IDS_4_5: begin
				tbl_id[4] = val[15:0];
				tbl_id[5] = val[31:16];
			end
			REG_SOURCE_IDS_6_7: begin
				tbl_id[6] = val[15:0];
				tbl_id[7] = val[31:16];
			end
			default: ;
		endcase
	endfunction

	// apply one report to the table and work out the snapshot it leaves behind
	function automatic fault_result_t predict_report(input fault_report_t r);
		fault_result_t res;
		snap_t         s;
		int            n;
		int            hit;
		int            i;
		n   = entries_used();
		hit = -1;
		res = '0;
		// first matching entry wins on duplicate ids
		for (i = 0; i < n; i++)
			if (hit < 0 && tbl_id[i] == r.sid)
				hit = i;
		if (hit >= 0) begin
			// a zero code clears the entry, any other code raises it
			if (r.code == '0) begin
				act_code[hit] = '0;
				cur_sev[hit]  = '0;
			end else begin
				act_code[hit]   = r.code;
				cur_sev[hit]    = r.sev;
				latch_code[hit] = r.code;
				if (r.sev > peak_sev[hit])
					peak_sev[hit] = r.sev;
			end
			rpt_cnt[hit] = rpt_cnt[hit] + 1'b1;
			// rebuild the system view; on a severity tie the earlier entry stays
			s       = '0;
			s.valid = 1'b1;
			for (i = 0; i < n; i++) begin
				if (latch_code[i] != '0)
					s.latched_n = s.latched_n + 1'b1;
				if (act_code[i] != '0) begin
					s.active_n = s.active_n + 1'b1;
					if (cur_sev[i] > s.worst_sev) begin
						s.worst_sev  = cur_sev[i];
						s.worst_id   = tbl_id[i];
						s.worst_code = act_code[i];
					end
				end
			end
			if (s != pub_snap) begin
				pub_seq       = pub_seq + 1'b1;
				pub_snap      = s;
				res.published = 1'b1;
			end
			res.reports  = rpt_cnt[hit];
			res.src_peak = peak_sev[hit];
		end else begin
			res.error = 1'b1;
		end
		res.snap = pub_snap;
		res.seq  = pub_seq;
		return res;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
				$time, what, want, got);
			failures++;
		end
	endtask

	// report driver: next report goes out once the current one has transferred
	always @(negedge clk) begin
		if (!report_valid || rep_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				report_valid <= 1'b0;
			end else if (report_queue.size() > 0) begin
				next_report = report_queue.pop_front();
				src_id       <= next_report.sid;
				fault_code   <= next_report.code;
				severity     <= next_report.sev;
				report_valid <= 1'b1;
				if (!quiet && $urandom_range(0, 11) == 0)
					send_gap = $urandom_range(1, 18);
			end else begin
				report_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure in random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 15) == 0) begin
			stall_left = $urandom_range(0, 17);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// monitor: check results, predict accepted reports, watch for a hang
	always @(posedge clk) begin
		rep_taken = report_valid && !report_stall;
		res_taken = result_valid && !result_stall;
		if (arst_n) begin
			// result transfer against the oldest prediction
			if (res_taken) begin
				seen_res = {error, published,
					{snapshot_valid, system_worst_severity, active_sources,
					latched_sources, worst_source_id, worst_code},
					sequence_res, source_reports, source_worst_severity};
				if (predicted_results.size() == 0) begin
					$display("%0t ns: result with no report outstanding, got 0x%0h",
						$time, seen_res);
					failures++;
				end else begin
					want_res = predicted_results.pop_front();
					n_results++;
					check_field("error", want_res.error, error);
					check_field("published", want_res.published, published);
					check_field("snapshot_valid", want_res.snap.valid, snapshot_valid);
					check_field("system_worst_severity", want_res.snap.worst_sev,
						system_worst_severity);
					check_field("active_sources", want_res.snap.active_n, active_sources);
					check_field("latched_sources", want_res.snap.latched_n,
						latched_sources);
					check_field("worst_source_id", want_res.snap.worst_id,
						worst_source_id);
					check_field("worst_code", want_res.snap.worst_code, worst_code);
					check_field("sequence_res", want_res.seq, sequence_res);
					check_field("source_reports", want_res.reports, source_reports);
					check_field("source_worst_severity", want_res.src_peak,
						source_worst_severity);
				end
			end
			// report transfer into the model
			if (rep_taken) begin
				want_res = predict_report({src_id, fault_code, severity});
				predicted_results.push_back(want_res);
				n_accepted++;
				if (want_res.published)
					n_publish++;
				if (want_res.error)
					n_unknown++;
			end
			if (cfg_valid && cfg_ready)
				n_cfg++;
			// watchdog on cycles without any transfer
			if (rep_taken || res_taken || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ns: no transfer for %0d cycles", $time, idle_cycles);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic post_report(input logic [ID_W-1:0] sid, input logic [CODE_W-1:0] code,
			input logic [SEV_W-1:0] sev);
		report_queue.push_back({sid, code, sev});
		n_posted++;
	endtask

	// sender holds off until every report has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (n_accepted != n_posted || predicted_results.size() != 0);
	endtask

	// random report, mostly from sources in use
	function automatic fault_report_t rand_report();
		fault_report_t r;
		int            n;
		int            pick;
		n    = entries_used();
		pick = $urandom_range(0, 19);
		if (n > 0 && pick < 16)
			r.sid = tbl_id[$urandom_range(0, n - 1)];
		else if (pick < 18)
			r.sid = tbl_id[$urandom_range(0, TABLE_SLOTS - 1)];
		else
			r.sid = 16'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 3)
			r.code = '0;
		else if (pick == 3)
			r.code = '1;
		else if (pick < 6)
			r.code = CODE_W'($urandom_range(1, 3));
		else
			r.code = 16'($urandom);
		// small severities make ties common
		pick = $urandom_range(0, 9);
		if (pick == 0)
			r.sev = '0;
		else if (pick == 1)
			r.sev = '1;
		else if (pick < 6)
			r.sev = SEV_W'($urandom_range(1, 4));
		else
			r.sev = 8'($urandom);
		return r;
	endfunction

	// new table: random size, ids either random or from a small pool
	task automatic randomize_table();
		logic [ID_W-1:0]       pool_base;
		logic [ID_W-1:0]       id_lo;
		logic [ID_W-1:0]       id_hi;
		logic [CFG_IDX_W-1:0]  idx;
		bit                    pooled;
		pool_base = 16'($urandom);
		pooled    = ($urandom_range(0, 2) == 0);
		if ($urandom_range(0, 5) == 0)
			write_reg(REG_SOURCE_COUNT, CFG_DATA_W'($urandom_range(9, 15)));
		else
			write_reg(REG_SOURCE_COUNT, CFG_DATA_W'($urandom_range(1, 8)));
		for (idx = REG_SOURCE_IDS_0_1; idx <= REG_SOURCE_IDS_6_7; idx++) begin
			id_lo = pooled ? pool_base + ID_W'($urandom_range(0, 2)) : 16'($urandom);
			id_hi = pooled ? pool_base + ID_W'($urandom_range(0, 2)) : 16'($urandom);
			write_reg(idx, {id_hi, id_lo});
		end
		if ($urandom_range(0, 1) == 0)
			write_reg(REG_SOURCE_IDS_6_7 + 1'b1 + CFG_IDX_W'($urandom_range(0, 2)),
				$urandom);
	endtask

	// stimulus sequence
	initial begin : stimulus
		int i;
		int ph;
		src_count = 4'd1;
		pub_seq   = '0;
		pub_snap  = '0;
		for (i = 0; i < TABLE_SLOTS; i++) begin
			tbl_id[i]     = '0;
			act_code[i]   = '0;
			latch_code[i] = '0;
			cur_sev[i]    = '0;
			peak_sev[i]   = '0;
			rpt_cnt[i]    = '0;
		end
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// reset table: one entry with id zero
		@(posedge clk);
		post_report(16'h0000, 16'h0000, 8'h00);   // clear on a clean entry still publishes
		post_report(16'h0001, 16'h0005, 8'h05);   // unknown id
		post_report(16'h0000, 16'hFFFF, 8'hFF);   // largest code and severity
		post_report(16'h0000, 16'h0001, 8'h00);   // active fault with no severity
		wait_drained();

		// full table with a duplicate id and an ignored register index
		write_reg(REG_SOURCE_COUNT, 32'd8);
		write_reg(REG_SOURCE_IDS_0_1, {16'hFFFF, 16'h1234});
		write_reg(REG_SOURCE_IDS_2_3, {16'h1234, 16'h0000});
		write_reg(REG_SOURCE_IDS_4_5, {16'h5555, 16'h00AA});
		write_reg(REG_SOURCE_IDS_6_7, {16'h8001, 16'hAAAA});
		write_reg(REG_SOURCE_IDS_6_7 + 1'b1, 32'hDEAD_BEEF);
		@(posedge clk);
		post_report(16'h1234, 16'h0007, 8'd100);  // duplicate id hits the first entry
		post_report(16'hFFFF, 16'h0009, 8'd100);  // severity tie keeps the earlier entry
		post_report(16'h1234, 16'h0000, 8'd50);   // clear moves the worst source
		post_report(16'h8001, 16'h8000, 8'd200);
		post_report(16'h8001, 16'h8000, 8'd200);  // unchanged snapshot, no publish
		post_report(16'h5555, 16'h0003, 8'hFF);
		post_report(16'h5555, 16'h0000, 8'h00);
		post_report(16'h0000, 16'h0001, 8'h01);   // id zero now hits entry 2; its old state stays in entry 0
		post_report(16'h4321, 16'h0001, 8'h01);
		wait_drained();

		// entries beyond the count keep state but drop out
		write_reg(REG_SOURCE_COUNT, 32'd3);
		@(posedge clk);
		post_report(16'h8001, 16'h0005, 8'h05);
		post_report(16'hFFFF, 16'h0000, 8'h00);
		wait_drained();

		// empty table rejects everything
		write_reg(REG_SOURCE_COUNT, 32'd0);
		@(posedge clk);
		post_report(16'h1234, 16'h0001, 8'h01);
		post_report(16'h0000, 16'h0000, 8'h00);
		wait_drained();

		// count above the table size saturates
		write_reg(REG_SOURCE_COUNT, 32'd15);
		@(posedge clk);
		post_report(16'h8001, 16'h0000, 8'h09);
		post_report(16'hAAAA, 16'h8000, 8'h80);
		post_report(16'h00AA, 16'h0002, 8'h7F);
		wait_drained();

		// random phases, each on a fresh table; the last one without idling
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			randomize_table();
			if (ph == RANDOM_PHASES - 1)
				quiet = 1'b1;
			@(posedge clk);
			repeat (PHASE_REPORTS)
				report_queue.push_back(rand_report());
			n_posted += PHASE_REPORTS;
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (predicted_results.size() != 0) begin
			$display("%0t ns: %0d results never came", $time, predicted_results.size());
			failures++;
		end
		$display("covered %0d reports over %0d register writes, %0d unknown sources,",
			n_accepted, n_cfg, n_unknown);
		$display("%0d snapshot publishes, %0d results checked, %0d mismatches",
			n_publish, n_results, failures);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
